@@ hdl/tclp_pkg.sv @@
// Shared types, character codes and helper functions for the threshold
// command line parser. No dependencies.
package tclp_pkg;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_I       = 8'h49;
    localparam logic [7:0] CH_M       = 8'h4D;
    localparam logic [7:0] CH_N       = 8'h4E;
    localparam logic [7:0] CH_X       = 8'h58;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;

    localparam int MAG_W = 17;
    localparam logic [MAG_W-1:0] MAG_LIMIT = 17'd32768;
    localparam logic [1:0] TOKENS_MAX = 2'd2;

    typedef enum logic [2:0] {
        PH_BETWEEN = 3'd0,
        PH_LEAD    = 3'd1,
        PH_SIGN    = 3'd2,
        PH_DIGITS  = 3'd3,
        PH_STOPPED = 3'd4,
        PH_CLOSED  = 3'd5
    } t_phase;

    typedef struct packed {
        logic        line_ok;
        logic [1:0]  tokens_found;
        logic [15:0] upper_value;
        logic [15:0] lower_value;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_line_done;

    function automatic logic is_delim(input logic [7:0] c);
        return (c == CH_A) || (c == CH_I) || (c == CH_M) || (c == CH_N) ||
               (c == CH_X) || (c == CH_COLON) || (c == CH_COMMA);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Clamp the magnitude and apply the sign as a 16-bit pattern.
    function automatic logic [15:0] token_value(input logic [MAG_W-1:0] mag,
                                                input logic neg);
        logic [MAG_W-1:0] m;
        m = mag;
        if (neg) begin
            if (m > MAG_LIMIT) m = MAG_LIMIT;
            return 16'(~m + 17'd1);
        end
        if (m > (MAG_LIMIT - 17'd1)) m = MAG_LIMIT - 17'd1;
        return m[15:0];
    endfunction

    // value * 10 + digit, saturated at the magnitude limit
    function automatic logic [MAG_W-1:0] accumulate(input logic [MAG_W-1:0] mag,
                                                    input logic [7:0] c);
        logic [20:0] v;
        v = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {17'd0, 4'(c - CH_ZERO)};
        return (v > 21'(MAG_LIMIT)) ? MAG_LIMIT : v[MAG_W-1:0];
    endfunction

endpackage

@@ hdl/tclp_token_fsm.sv @@
// Token state machine: line position, token phase, running value.
// Processes one registered byte per step. Depends on tclp_pkg.
module tclp_token_fsm #(
    parameter int LINE_LENGTH = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_byte_valid,
    input  logic [7:0]             i_byte,
    input  logic                   i_step,
    output tclp_pkg::t_line_done   o_done
);
    import tclp_pkg::*;

    localparam int POS_W = $clog2(LINE_LENGTH);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(LINE_LENGTH - 1);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [1:0]       r_count, n_count;
    t_phase           r_phase, n_phase;
    logic             r_neg, n_neg;
    logic [MAG_W-1:0] r_mag, n_mag;
    logic [15:0]      r_first, n_first;
    logic             r_ended, n_ended;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            r_phase <= PH_BETWEEN;
            r_neg   <= 1'b0;
            r_mag   <= '0;
            r_first <= '0;
            r_ended <= 1'b0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_count <= n_count;
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
            r_first <= n_first;
            r_ended <= n_ended;
        end
    end

    always_comb begin
        logic line_end;
        logic [15:0] tok;
        n_count = r_count;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_first = r_first;
        n_ended = r_ended;
        line_end = (i_byte == CH_NEWLINE) || (r_pos == LAST_POS);

        if ((i_byte != CH_NEWLINE) && !r_ended) begin
            if (i_byte == CH_NUL) begin
                n_ended = 1'b1;
            end else if (r_phase != PH_CLOSED) begin
                if (is_delim(i_byte)) begin
                    if (r_phase != PH_BETWEEN) begin
                        if (r_count >= TOKENS_MAX) begin
                            n_phase = PH_CLOSED;
                        end else begin
                            n_first = token_value(r_mag, r_neg);
                            n_phase = PH_BETWEEN;
                        end
                    end
                end else begin
                    // open a new token
                    if (r_phase == PH_BETWEEN) begin
                        n_count = r_count + 2'd1;
                        n_mag   = '0;
                        n_neg   = 1'b0;
                        n_phase = PH_LEAD;
                    end
                    unique case (n_phase)
                        PH_LEAD: begin
                            if (is_space(i_byte)) begin
                                n_phase = PH_LEAD;
                            end else if ((i_byte == CH_PLUS) || (i_byte == CH_MINUS)) begin
                                n_neg   = (i_byte == CH_MINUS);
                                n_phase = PH_SIGN;
                            end else if (is_digit(i_byte)) begin
                                n_mag   = accumulate(n_mag, i_byte);
                                n_phase = PH_DIGITS;
                            end else begin
                                n_phase = PH_STOPPED;
                            end
                        end
                        PH_SIGN, PH_DIGITS: begin
                            if (is_digit(i_byte)) begin
                                n_mag   = accumulate(n_mag, i_byte);
                                n_phase = PH_DIGITS;
                            end else begin
                                n_phase = PH_STOPPED;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end

        // result from the updated state
        tok = token_value(n_mag, n_neg);
        o_done.valid = i_byte_valid && line_end;
        o_done.res.tokens_found = n_count;
        o_done.res.line_ok      = (n_count >= TOKENS_MAX);
        o_done.res.lower_value  = '0;
        o_done.res.upper_value  = '0;
        if (n_count == 2'd1) begin
            o_done.res.lower_value = (n_phase == PH_BETWEEN) ? n_first : tok;
        end else if (n_count >= TOKENS_MAX) begin
            o_done.res.lower_value = n_first;
            o_done.res.upper_value = tok;
        end

        n_pos = r_pos + POS_W'(1);
        if (line_end) begin
            // back to reset state for the next line
            n_pos   = '0;
            n_count = '0;
            n_phase = PH_BETWEEN;
            n_neg   = 1'b0;
            n_mag   = '0;
            n_first = '0;
            n_ended = 1'b0;
        end
    end

endmodule

@@ hdl/tclp_out_reg.sv @@
// Result register for the master stream side; holds a line result until taken.
// Depends on tclp_pkg.
module tclp_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  tclp_pkg::t_result    i_res,
    output logic                 o_busy,
    input  logic                 m_axis_tready,
    output logic                 m_axis_tvalid,
    output logic [39:0]          m_axis_tdata
);
    import tclp_pkg::*;

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    // full and not drained this cycle
    assign o_busy        = r_valid && !m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {5'd0, r_res};

endmodule

@@ hdl/threshold_command_line_parser_core.sv @@
// Threshold command line parser: one received byte per beat, one result per line.
// Path: the ending beat passes the input register, then loads the output register.
// Throughput: one byte beat per cycle while no line result waits on an untaken result.
// Reset: synchronous active-low i_rst_n clears the line state and both valid flags.
// Depends on tclp_pkg, tclp_token_fsm and tclp_out_reg.
module threshold_command_line_parser_core #(
    parameter int LINE_LENGTH = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // [15:0] lower_value, [31:16] upper_value,
                                        // [33:32] tokens_found, [34] line_ok, rest zero
);
    import tclp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_line_done done;
    logic       out_busy;
    logic       step;

    // Hold the input beat while a line result would collide with an untaken result.
    assign step          = r_in_valid && !(done.valid && out_busy);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Advance the token state by one byte.
    tclp_token_fsm #(
        .LINE_LENGTH (LINE_LENGTH)
    ) u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (r_in_valid),
        .i_byte       (r_in_byte),
        .i_step       (step),
        .o_done       (done)
    );

    // Capture the line result when the ending byte is processed.
    tclp_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (step && done.valid),
        .i_res         (done.res),
        .o_busy        (out_busy),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
